[design/ptre_pkg.sv]
// Shared types, codes and helper functions of the pin threshold rule engine.
`default_nettype none

package ptre_pkg;

  // Table sizes and drive limits
  localparam int RULES     = 8;
  localparam int PINS      = 40;
  localparam int MAX_OUT   = 8;
  localparam int PWM_TOP   = 1000;
  localparam int SERVO_TOP = 180;
  localparam int QDEPTH    = 2;

  localparam int RIDX_W = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CNT_W  = $clog2(RULES + 1);
  localparam int PIDX_W = (PINS > 1) ? $clog2(PINS) : 1;
  localparam int OCNT_W = $clog2(MAX_OUT + 1);
  localparam int QP_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ACT_EVENT = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_MODE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CMP_GT = 3'd0,
    CMP_GE = 3'd1,
    CMP_LT = 3'd2,
    CMP_LE = 3'd3,
    CMP_EQ = 3'd4,
    CMP_NE = 3'd5
  } cmp_op_e;

  // Pin output modes, also the drive kind of a result
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_OUT   = 2'd1,
    MODE_PWM   = 2'd2,
    MODE_SERVO = 2'd3
  } mode_e;

  // Event kinds
  typedef enum logic [1:0] {
    EVK_OTHER   = 2'd0,
    EVK_DIGITAL = 2'd1,
    EVK_ANALOG  = 2'd2,
    EVK_SPARE   = 2'd3
  } ev_kind_e;

  typedef enum logic [1:0] {
    RES_DRIVE  = 2'd0,
    RES_ACCEPT = 2'd1,
    RES_REJECT = 2'd2,
    RES_SPARE  = 2'd3
  } res_kind_e;

  // Last outcome a rule acted on
  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_ELSE  = 2'd1,
    MEM_THEN  = 2'd2,
    MEM_SPARE = 2'd3
  } rule_mem_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } back_st_e;

  // Classified command passed from front to back
  typedef struct packed {
    action_e            action;
    logic               good;
    logic [2:0]         slot;
    logic               enabled;
    logic [5:0]         pin;
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [5:0]         then_pin;
    logic signed [31:0] then_value;
    logic               else_present;
    logic [5:0]         else_pin;
    logic signed [31:0] else_value;
    logic [1:0]         kind;
  } cmd_t;

  typedef struct packed {
    res_kind_e  kind;
    logic [5:0] dest_pin;
    logic [9:0] value;
    logic [1:0] dkind;
    logic [2:0] rule_index;
    logic       last;
  } res_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic vld;
  } q_stat_t;

  function automatic logic cmp_hit(logic signed [31:0] v, logic [2:0] op,
                                   logic signed [31:0] th);
    logic r;
    case (op)
      CMP_GT:  r = v > th;
      CMP_GE:  r = v >= th;
      CMP_LT:  r = v < th;
      CMP_LE:  r = v <= th;
      CMP_EQ:  r = v == th;
      CMP_NE:  r = v != th;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] shape_value(logic [1:0] mode, logic signed [31:0] v);
    logic [9:0] r;
    case (mode)
      MODE_OUT: r = {9'd0, |v};
      MODE_PWM: begin
        if (v < 0) r = '0;
        else if (v > 32'(PWM_TOP)) r = 10'(PWM_TOP);
        else r = v[9:0];
      end
      MODE_SERVO: begin
        if (v < 0) r = '0;
        else if (v > 32'(SERVO_TOP)) r = 10'(SERVO_TOP);
        else r = v[9:0];
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[design/ptre_front.sv]
// Front end: accepts input transactions, validates and filters them into commands.
`default_nettype none

module ptre_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [2:0]         slot_i,
  input  logic               enabled_i,
  input  logic [5:0]         pin_i,
  input  logic [2:0]         compare_op_i,
  input  logic signed [31:0] sample_or_threshold_i,
  input  logic [5:0]         then_pin_i,
  input  logic signed [31:0] then_value_i,
  input  logic               else_present_i,
  input  logic [5:0]         else_pin_i,
  input  logic signed [31:0] else_value_i,
  input  logic [1:0]         kind_i,
  input  ptre_pkg::q_stat_t  q_stat_i,
  output logic               push_o,
  output ptre_pkg::cmd_t     cmd_o
);
  import ptre_pkg::*;

  logic    pin_ok;
  logic    slot_ok;
  logic    write_ok;
  logic    drop;
  action_e act;

  // Validate and filter
  always_comb begin
    act     = action_e'(action_i);
    pin_ok  = int'(pin_i) < PINS;
    slot_ok = int'(slot_i) < RULES;
    write_ok = slot_ok && pin_ok && (compare_op_i <= CMP_NE) &&
               (int'(then_pin_i) < PINS) && (then_pin_i != pin_i) &&
               !(else_present_i && (else_pin_i == pin_i));
    case (act)
      ACT_EVENT: drop = !pin_ok || !(kind_i == EVK_DIGITAL || kind_i == EVK_ANALOG);
      ACT_MODE:  drop = !pin_ok;
      default:   drop = 1'b0;
    endcase
  end

  // Build the command
  always_comb begin
    cmd_o.action       = act;
    cmd_o.good         = (act == ACT_WRITE) ? write_ok : slot_ok;
    cmd_o.slot         = slot_i;
    cmd_o.enabled      = enabled_i;
    cmd_o.pin          = pin_i;
    cmd_o.op           = compare_op_i;
    cmd_o.value        = sample_or_threshold_i;
    cmd_o.then_pin     = then_pin_i;
    cmd_o.then_value   = then_value_i;
    cmd_o.else_present = else_present_i;
    cmd_o.else_pin     = else_pin_i;
    cmd_o.else_value   = else_value_i;
    cmd_o.kind         = kind_i;
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full && !drop;

endmodule

`default_nettype wire

[design/ptre_queue.sv]
// Short command queue between front and back.
`default_nettype none

module ptre_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ptre_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output ptre_pkg::q_stat_t stat_o,
  output ptre_pkg::cmd_t    cmd_o
);
  import ptre_pkg::*;

  cmd_t            ent_q [QDEPTH];
  logic [QP_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full = cnt_q == QC_W'(QDEPTH);
  assign stat_o.vld  = cnt_q != '0;
  assign cmd_o       = ent_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    do_push  = push_i && !stat_o.full;
    do_pop   = pop_i && stat_o.vld;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) wr_ptr_d = (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop) rd_ptr_d = (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    cnt_d = cnt_q + QC_W'(do_push) - QC_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_ptr_q] <= cmd_i;
  end

endmodule

`default_nettype wire

[design/ptre_back.sv]
// Back end: rule tables, pin mode memory, rule scan and result registers.
`default_nettype none

module ptre_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptre_pkg::q_stat_t q_stat_i,
  input  ptre_pkg::cmd_t    q_cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ptre_pkg::res_t    res_o
);
  import ptre_pkg::*;

  // Rule tables
  logic               rv_q   [RULES];
  logic [1:0]         rmem_q [RULES];
  logic               ren_q  [RULES];
  logic [5:0]         rsrc_q [RULES];
  logic [2:0]         rop_q  [RULES];
  logic signed [31:0] rthr_q [RULES];
  logic [5:0]         tpin_q [RULES];
  logic signed [31:0] tval_q [RULES];
  logic               eprs_q [RULES];
  logic [5:0]         epin_q [RULES];
  logic signed [31:0] eval_q [RULES];

  // Pin mode memory with per-entry valid bits
  logic [1:0] pmode_mem   [PINS];
  logic       pmode_vld_q [PINS];

  back_st_e           st_q, st_d;
  logic [5:0]         ev_pin_q;
  logic signed [31:0] ev_sample_q;
  logic [CNT_W-1:0]   a_idx_q;

  // Second scan stage
  logic               b_vld_q;
  logic [RIDX_W-1:0]  b_idx_q;
  logic               b_hit_q;
  logic               b_fire_q;
  logic               b_drive_q;
  logic [5:0]         b_pin_q;
  logic signed [31:0] b_val_q;
  logic               b_pin_ok_q;
  logic [1:0]         mode_rd_q;
  logic               mode_vld_rd_q;

  logic [OCNT_W-1:0]  n_q, n_d;
  logic               pend_vld_q, pend_vld_d;
  res_t               pend_q, pend_d;
  logic               out_vld_q, out_vld_d;
  res_t               out_q, out_d;

  logic               out_free;
  logic [RIDX_W-1:0]  slot_idx;
  logic [PIDX_W-1:0]  mode_idx;
  logic               wr_rule, clr_rule, wr_mode, start_scan, cmd_good;

  logic [RIDX_W-1:0]  a_i;
  logic               a_act, a_hit, a_fire, a_drive, a_pin_ok;
  logic [5:0]         a_pin;
  logic signed [31:0] a_val;
  logic [1:0]         a_next;
  logic [PIDX_W-1:0]  pm_addr;
  logic               adv;

  logic [1:0]         b_mode;
  logic               b_ok, b_upd, b_emit, b_stall;
  res_t               b_res;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;
  assign slot_idx    = RIDX_W'(q_cmd_i.slot);
  assign mode_idx    = PIDX_W'(q_cmd_i.pin);

  // First scan stage: read the rule, compare, pick the drive
  always_comb begin
    a_i      = a_idx_q[RIDX_W-1:0];
    a_act    = (st_q == ST_SCAN) && (a_idx_q < CNT_W'(RULES));
    a_hit    = cmp_hit(ev_sample_q, rop_q[a_i], rthr_q[a_i]);
    a_next   = a_hit ? MEM_THEN : MEM_ELSE;
    a_fire   = a_act && rv_q[a_i] && ren_q[a_i] && (rsrc_q[a_i] == ev_pin_q) &&
               (rmem_q[a_i] != a_next);
    a_drive  = a_hit || eprs_q[a_i];
    a_pin    = a_hit ? tpin_q[a_i] : epin_q[a_i];
    a_val    = a_hit ? tval_q[a_i] : eval_q[a_i];
    a_pin_ok = int'(a_pin) < PINS;
    pm_addr  = PIDX_W'(a_pin);
  end

  // Second scan stage: shape the drive with the destination mode
  always_comb begin
    b_mode  = mode_vld_rd_q ? mode_rd_q : MODE_NONE;
    b_ok    = b_pin_ok_q && (b_mode != MODE_NONE);
    b_upd   = b_vld_q && b_fire_q && (!b_drive_q || b_ok);
    b_emit  = b_vld_q && b_fire_q && b_drive_q && b_ok && (n_q < OCNT_W'(MAX_OUT));
    b_stall = b_emit && pend_vld_q && !out_free;
    adv     = !b_stall;
    b_res.kind       = RES_DRIVE;
    b_res.dest_pin   = b_pin_q;
    b_res.value      = shape_value(b_mode, b_val_q);
    b_res.dkind      = b_mode;
    b_res.rule_index = 3'(b_idx_q);
    b_res.last       = 1'b0;
  end

  // Next state and outputs
  always_comb begin
    st_d       = st_q;
    pop_o      = 1'b0;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    n_d        = n_q;
    start_scan = 1'b0;
    wr_rule    = 1'b0;
    clr_rule   = 1'b0;
    wr_mode    = 1'b0;
    cmd_good   = 1'b0;
    if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (q_stat_i.vld) begin
          case (q_cmd_i.action)
            ACT_EVENT: begin
              pop_o      = 1'b1;
              start_scan = 1'b1;
              n_d        = '0;
              st_d       = ST_SCAN;
            end
            ACT_MODE: begin
              pop_o   = 1'b1;
              wr_mode = 1'b1;
            end
            default: begin
              if (out_free) begin
                pop_o    = 1'b1;
                cmd_good = (q_cmd_i.action == ACT_WRITE) ? q_cmd_i.good :
                           (q_cmd_i.good && rv_q[slot_idx]);
                wr_rule  = (q_cmd_i.action == ACT_WRITE) && cmd_good;
                clr_rule = (q_cmd_i.action == ACT_CLEAR) && cmd_good;
                out_vld_d        = 1'b1;
                out_d.kind       = cmd_good ? RES_ACCEPT : RES_REJECT;
                out_d.dest_pin   = '0;
                out_d.value      = '0;
                out_d.dkind      = '0;
                out_d.rule_index = q_cmd_i.slot;
                out_d.last       = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Hold one drive back until the next one or the end marks it
        if (b_emit && adv) begin
          if (pend_vld_q) begin
            out_d     = pend_q;
            out_vld_d = 1'b1;
          end
          pend_d     = b_res;
          pend_vld_d = 1'b1;
          n_d        = n_q + 1'b1;
        end
        if (!a_act && !b_vld_q) st_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          st_d = ST_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          st_d       = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      n_q        <= '0;
      b_vld_q    <= 1'b0;
      a_idx_q    <= '0;
    end else begin
      st_q       <= st_d;
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
      n_q        <= n_d;
      if (start_scan) begin
        a_idx_q <= '0;
        b_vld_q <= 1'b0;
      end else if (st_q == ST_SCAN && adv) begin
        b_vld_q <= a_act;
        if (a_act) a_idx_q <= a_idx_q + 1'b1;
      end
    end
  end

  // Rule valid bits, rule memory and pin mode valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RULES; i++) begin
        rv_q[i]   <= 1'b0;
        rmem_q[i] <= MEM_NONE;
      end
      for (int p = 0; p < PINS; p++) pmode_vld_q[p] <= 1'b0;
    end else begin
      if (wr_rule) begin
        rv_q[slot_idx]   <= 1'b1;
        rmem_q[slot_idx] <= MEM_NONE;
      end
      if (clr_rule) begin
        rv_q[slot_idx]   <= 1'b0;
        rmem_q[slot_idx] <= MEM_NONE;
      end
      if (st_q == ST_SCAN && adv && b_upd) rmem_q[b_idx_q] <= b_hit_q ? MEM_THEN : MEM_ELSE;
      if (wr_mode) pmode_vld_q[mode_idx] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
    if (start_scan) begin
      ev_pin_q    <= q_cmd_i.pin;
      ev_sample_q <= q_cmd_i.value;
    end
    if (st_q == ST_SCAN && adv) begin
      b_idx_q    <= a_i;
      b_hit_q    <= a_hit;
      b_fire_q   <= a_fire;
      b_drive_q  <= a_drive;
      b_pin_q    <= a_pin;
      b_val_q    <= a_val;
      b_pin_ok_q <= a_pin_ok;
    end
    if (wr_rule) begin
      ren_q[slot_idx]  <= q_cmd_i.enabled;
      rsrc_q[slot_idx] <= q_cmd_i.pin;
      rop_q[slot_idx]  <= q_cmd_i.op;
      rthr_q[slot_idx] <= q_cmd_i.value;
      tpin_q[slot_idx] <= q_cmd_i.then_pin;
      tval_q[slot_idx] <= q_cmd_i.then_value;
      eprs_q[slot_idx] <= q_cmd_i.else_present;
      epin_q[slot_idx] <= q_cmd_i.else_pin;
      eval_q[slot_idx] <= q_cmd_i.else_value;
    end
  end

  // Pin mode memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_mode) pmode_mem[mode_idx] <= q_cmd_i.kind;
    if (st_q == ST_SCAN && adv) begin
      mode_rd_q     <= pmode_mem[pm_addr];
      mode_vld_rd_q <= pmode_vld_q[pm_addr];
    end
  end

endmodule

`default_nettype wire

[design/pin_threshold_rule_engine.sv]
// Top level of the pin threshold rule engine.
`default_nettype none

// Pin threshold rule engine. A front end validates each input transaction and
// drops those with no effect (events on pins out of range or of another kind,
// mode writes to pins out of range); the rest go through a two-entry command
// queue to the back end. A pin event walks every rule slot in a two-stage
// scan (rule read and compare, then pin mode memory read and drive shaping),
// which the result side can stall. Drive results come out in slot order, at
// most eight per event, with last set on the final one; write and clear
// results carry last set. State is ready straight out of reset: no clearing
// pass is needed.
module pin_threshold_rule_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [2:0]         slot_i,
  input  logic               enabled_i,
  input  logic [5:0]         pin_i,
  input  logic [2:0]         compare_op_i,
  input  logic signed [31:0] sample_or_threshold_i,
  input  logic [5:0]         then_pin_i,
  input  logic signed [31:0] then_value_i,
  input  logic               else_present_i,
  input  logic [5:0]         else_pin_i,
  input  logic signed [31:0] else_value_i,
  input  logic [1:0]         kind_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         result_kind_o,
  output logic [5:0]         dest_pin_o,
  output logic [9:0]         drive_value_o,
  output logic [1:0]         drive_kind_o,
  output logic [2:0]         rule_index_o,
  output logic               last_o
);
  import ptre_pkg::*;

  q_stat_t q_stat;
  cmd_t    f_cmd;
  cmd_t    q_cmd;
  logic    push;
  logic    pop;
  res_t    res;

  ptre_front u_front (
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .action_i              (action_i),
    .slot_i                (slot_i),
    .enabled_i             (enabled_i),
    .pin_i                 (pin_i),
    .compare_op_i          (compare_op_i),
    .sample_or_threshold_i (sample_or_threshold_i),
    .then_pin_i            (then_pin_i),
    .then_value_i          (then_value_i),
    .else_present_i        (else_present_i),
    .else_pin_i            (else_pin_i),
    .else_value_i          (else_value_i),
    .kind_i                (kind_i),
    .q_stat_i              (q_stat),
    .push_o                (push),
    .cmd_o                 (f_cmd)
  );

  ptre_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (f_cmd),
    .pop_i  (pop),
    .stat_o (q_stat),
    .cmd_o  (q_cmd)
  );

  ptre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // Split the result onto its ports
  assign result_kind_o = res.kind;
  assign dest_pin_o    = res.dest_pin;
  assign drive_value_o = res.value;
  assign drive_kind_o  = res.dkind;
  assign rule_index_o  = res.rule_index;
  assign last_o        = res.last;

endmodule

`default_nettype wire

[design/ptre_checker.sv]
// Port-level assertions for the pin threshold rule engine and their binding.
`default_nettype none

module ptre_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] result_kind_o,
  input logic [5:0] dest_pin_o,
  input logic [9:0] drive_value_o,
  input logic [1:0] drive_kind_o,
  input logic [2:0] rule_index_o,
  input logic       last_o
);
  import ptre_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_kind_o) && $stable(dest_pin_o) &&
      $stable(drive_value_o) && $stable(drive_kind_o) && $stable(rule_index_o) &&
      $stable(last_o))
    else $error("stalled result changed");

  // Write and clear results are single, empty transactions
  a_write_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != RES_DRIVE |->
      (result_kind_o == RES_ACCEPT || result_kind_o == RES_REJECT) && last_o &&
      dest_pin_o == '0 && drive_value_o == '0 && drive_kind_o == '0)
    else $error("malformed write result");

  // Drive values respect the limit of their mode
  a_drive_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RES_DRIVE |->
      (drive_kind_o == MODE_OUT && drive_value_o <= 10'd1) ||
      (drive_kind_o == MODE_PWM && drive_value_o <= 10'(PWM_TOP)) ||
      (drive_kind_o == MODE_SERVO && drive_value_o <= 10'(SERVO_TOP)))
    else $error("drive value outside its mode range");

endmodule

bind pin_threshold_rule_engine ptre_checker u_ptre_checker (.*);

`default_nettype wire

[tb/sv/ptre_drive_checker.sv]
// Checker for the pin threshold rule engine: predicts results and compares them.
`timescale 1ns / 100ps

module ptre_drive_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         action_i,
  input  logic [2:0]         slot_i,
  input  logic               enabled_i,
  input  logic [5:0]         pin_i,
  input  logic [2:0]         compare_op_i,
  input  logic signed [31:0] sample_or_threshold_i,
  input  logic [5:0]         then_pin_i,
  input  logic signed [31:0] then_value_i,
  input  logic               else_present_i,
  input  logic [5:0]         else_pin_i,
  input  logic signed [31:0] else_value_i,
  input  logic [1:0]         kind_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         result_kind_i,
  input  logic [5:0]         dest_pin_i,
  input  logic [9:0]         drive_value_i,
  input  logic [1:0]         drive_kind_i,
  input  logic [2:0]         rule_index_i,
  input  logic               last_i,
  output int                 err_count_o,
  output int                 pending_o
);
  import ptre_pkg::*;

  // Predicted rule table, rule memories and pin modes
  logic               rule_valid [RULES];
  logic               rule_en    [RULES];
  logic [5:0]         rule_src   [RULES];
  logic [2:0]         rule_op    [RULES];
  logic signed [31:0] rule_thr   [RULES];
  logic [5:0]         then_pin_q [RULES];
  logic signed [31:0] then_val_q [RULES];
  logic               else_on_q  [RULES];
  logic [5:0]         else_pin_q [RULES];
  logic signed [31:0] else_val_q [RULES];
  rule_mem_e          rule_mem   [RULES];
  mode_e              pin_mode   [PINS];

  // Results still owed by the block, oldest first
  res_t               due_results [$];
  int                 errors;

  function automatic logic outcome(logic signed [31:0] v, logic [2:0] op,
                                   logic signed [31:0] th);
    case (cmp_op_e'(op))
      CMP_GT:  return v > th;
      CMP_GE:  return v >= th;
      CMP_LT:  return v < th;
      CMP_LE:  return v <= th;
      CMP_EQ:  return v == th;
      CMP_NE:  return v != th;
      default: return 1'b0;
    endcase
  endfunction

  // Shape a drive by the destination mode; fail on pins that are not outputs
  function automatic logic shape_drive(input logic [5:0] pin, input logic signed [31:0] v,
                                       output logic [9:0] val, output mode_e dk);
    val = '0;
    dk  = MODE_NONE;
    if (pin >= PINS) return 1'b0;
    dk = pin_mode[pin];
    case (dk)
      MODE_OUT:   val = (v != 0) ? 10'd1 : 10'd0;
      MODE_PWM:   val = (v < 0) ? 10'd0 : (v > PWM_TOP) ? 10'(PWM_TOP) : v[9:0];
      MODE_SERVO: val = (v < 0) ? 10'd0 : (v > SERVO_TOP) ? 10'(SERVO_TOP) : v[9:0];
      default:    return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic res_t slot_result(res_kind_e k, logic [2:0] slot);
    res_t r;
    r            = '0;
    r.kind       = k;
    r.rule_index = slot;
    r.last       = 1'b1;
    return r;
  endfunction

  // Apply one accepted transaction to the predicted state and queue its results
  task automatic predict_transaction();
    logic      hit;
    logic      ok;
    logic      drove;
    logic      good;
    logic [9:0] val;
    mode_e     dk;
    rule_mem_e nxt;
    res_t      r;
    int        n;
    n = 0;
    case (action_e'(action_i))
      ACT_EVENT: begin
        if (pin_i < PINS && (kind_i == EVK_DIGITAL || kind_i == EVK_ANALOG)) begin
          for (int i = 0; i < RULES; i++) begin
            if (!rule_valid[i] || !rule_en[i] || rule_src[i] != pin_i) continue;
            hit = outcome(sample_or_threshold_i, rule_op[i], rule_thr[i]);
            nxt = hit ? MEM_THEN : MEM_ELSE;
            if (rule_mem[i] == nxt) continue;
            if (hit) begin
              ok    = shape_drive(then_pin_q[i], then_val_q[i], val, dk);
              drove = ok;
            end else if (else_on_q[i]) begin
              ok    = shape_drive(else_pin_q[i], else_val_q[i], val, dk);
              drove = ok;
            end else begin
              ok    = 1'b1;
              drove = 1'b0;
            end
            // A failed drive keeps the old memory so the rule retries
            if (!ok) continue;
            rule_mem[i] = nxt;
            if (drove && n < MAX_OUT) begin
              r            = '0;
              r.kind       = RES_DRIVE;
              r.dest_pin   = hit ? then_pin_q[i] : else_pin_q[i];
              r.value      = val;
              r.dkind      = dk;
              r.rule_index = 3'(i);
              due_results.push_back(r);
              n++;
            end
          end
          if (n > 0) begin
            r      = due_results[due_results.size() - 1];
            r.last = 1'b1;
            due_results[due_results.size() - 1] = r;
          end
        end
      end
      ACT_WRITE: begin
        good = slot_i < RULES && pin_i < PINS && compare_op_i <= CMP_NE &&
               then_pin_i < PINS && then_pin_i != pin_i &&
               !(else_present_i && else_pin_i == pin_i);
        if (good) begin
          rule_valid[slot_i] = 1'b1;
          rule_en[slot_i]    = enabled_i;
          rule_src[slot_i]   = pin_i;
          rule_op[slot_i]    = compare_op_i;
          rule_thr[slot_i]   = sample_or_threshold_i;
          then_pin_q[slot_i] = then_pin_i;
          then_val_q[slot_i] = then_value_i;
          else_on_q[slot_i]  = else_present_i;
          else_pin_q[slot_i] = else_pin_i;
          else_val_q[slot_i] = else_value_i;
          rule_mem[slot_i]   = MEM_NONE;
        end
        due_results.push_back(slot_result(good ? RES_ACCEPT : RES_REJECT, slot_i));
      end
      ACT_CLEAR: begin
        good = slot_i < RULES && rule_valid[slot_i];
        if (good) begin
          rule_valid[slot_i] = 1'b0;
          rule_en[slot_i]    = 1'b0;
          rule_src[slot_i]   = '0;
          rule_op[slot_i]    = '0;
          rule_thr[slot_i]   = '0;
          rule_mem[slot_i]   = MEM_NONE;
        end
        due_results.push_back(slot_result(good ? RES_ACCEPT : RES_REJECT, slot_i));
      end
      ACT_MODE: begin
        if (pin_i < PINS) pin_mode[pin_i] = mode_e'(kind_i);
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Match one result transaction against the oldest prediction
  task automatic check_result();
    res_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, got kind %0d pin %0d value %0d",
               $time, result_kind_i, dest_pin_i, drive_value_i);
      $display("%0t:   drive kind %0d rule %0d last %0d",
               $time, drive_kind_i, rule_index_i, last_i);
      errors++;
    end else begin
      want = due_results.pop_front();
      compare_field("result_kind", want.kind, result_kind_i);
      compare_field("dest_pin", want.dest_pin, dest_pin_i);
      compare_field("drive_value", want.value, drive_value_i);
      compare_field("drive_kind", want.dkind, drive_kind_i);
      compare_field("rule_index", want.rule_index, rule_index_i);
      compare_field("last", want.last, last_i);
    end
  endtask

  // Watch both channels; publish counts through registered outputs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RULES; i++) begin
        rule_valid[i] = 1'b0;
        rule_en[i]    = 1'b0;
        rule_src[i]   = '0;
        rule_op[i]    = '0;
        rule_thr[i]   = '0;
        then_pin_q[i] = '0;
        then_val_q[i] = '0;
        else_on_q[i]  = 1'b0;
        else_pin_q[i] = '0;
        else_val_q[i] = '0;
        rule_mem[i]   = MEM_NONE;
      end
      for (int p = 0; p < PINS; p++) pin_mode[p] = MODE_NONE;
      due_results.delete();
      errors = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) predict_transaction();
      err_count_o <= errors;
      pending_o   <= due_results.size();
    end
  end

endmodule

[tb/sv/pin_threshold_rule_engine_tb.sv]
// Testbench top for the pin threshold rule engine: stimulus, idling and verdict.
`timescale 1ns / 100ps

module pin_threshold_rule_engine_tb;
  import ptre_pkg::*;

  localparam int ITEMS       = 230;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 40;
  localparam logic [2:0] OP_BAD = 3'(CMP_NE) + 3'd1;

  typedef struct {
    action_e            act;
    logic [2:0]         slot;
    logic               en;
    logic [5:0]         pin;
    logic [2:0]         op;
    logic signed [31:0] level;
    logic [5:0]         then_pin;
    logic signed [31:0] then_val;
    logic               else_on;
    logic [5:0]         else_pin;
    logic signed [31:0] else_val;
    logic [1:0]         kind;
  } txn_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         action_i;
  logic [2:0]         slot_i;
  logic               enabled_i;
  logic [5:0]         pin_i;
  logic [2:0]         compare_op_i;
  logic signed [31:0] sample_or_threshold_i;
  logic [5:0]         then_pin_i;
  logic signed [31:0] then_value_i;
  logic               else_present_i;
  logic [5:0]         else_pin_i;
  logic signed [31:0] else_value_i;
  logic [1:0]         kind_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         result_kind_o;
  logic [5:0]         dest_pin_o;
  logic [9:0]         drive_value_o;
  logic [1:0]         drive_kind_o;
  logic [2:0]         rule_index_o;
  logic               last_o;

  int   err_count;
  int   pending;
  int   cycles = 0;
  int   stall_run = 0;
  int   counted;
  logic calm = 1'b0;
  txn_t t;

  pin_threshold_rule_engine dut (.*);

  ptre_drive_checker u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .action_i              (action_i),
    .slot_i                (slot_i),
    .enabled_i             (enabled_i),
    .pin_i                 (pin_i),
    .compare_op_i          (compare_op_i),
    .sample_or_threshold_i (sample_or_threshold_i),
    .then_pin_i            (then_pin_i),
    .then_value_i          (then_value_i),
    .else_present_i        (else_present_i),
    .else_pin_i            (else_pin_i),
    .else_value_i          (else_value_i),
    .kind_i                (kind_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .result_kind_i         (result_kind_o),
    .dest_pin_i            (dest_pin_o),
    .drive_value_i         (drive_value_o),
    .drive_kind_i          (drive_kind_o),
    .rule_index_i          (rule_index_o),
    .last_i                (last_o),
    .err_count_o           (err_count),
    .pending_o             (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Idle length: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 40);
  endfunction

  // Stall the result side in random stretches
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_run = $urandom_range(0, 10);
    end else begin
      stall_run = gap_len();
      if (stall_run > 0) begin
        out_stall_i <= 1'b1;
        stall_run--;
      end else begin
        stall_run = $urandom_range(0, 10);
      end
    end
  end

  // Destination pins, also the targets of mode writes: 0..7 and the two top pins
  function automatic logic [5:0] dest_pick();
    int r;
    r = $urandom_range(0, 9);
    return (r < 8) ? 6'(r) : 6'(PINS - 10 + r);
  endfunction

  function automatic logic signed [31:0] level_pick();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) begin
      case ($urandom_range(0, 2))
        0:       return -100;
        1:       return 0;
        default: return 100;
      endcase
    end
    if (r == 8) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic signed [31:0] value_pick();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 1200);
      4, 5:       return -$signed(32'($urandom_range(0, 50)));
      6, 7:       return $urandom;
      8:          return 0;
      default:    return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // Random filler so unused fields still toggle
  function automatic txn_t noise();
    txn_t n;
    n.act      = action_e'($urandom_range(0, 3));
    n.slot     = 3'($urandom);
    n.en       = 1'($urandom);
    n.pin      = 6'($urandom);
    n.op       = 3'($urandom);
    n.level    = $urandom;
    n.then_pin = 6'($urandom);
    n.then_val = $urandom;
    n.else_on  = 1'($urandom);
    n.else_pin = 6'($urandom);
    n.else_val = $urandom;
    n.kind     = 2'($urandom);
    return n;
  endfunction

  function automatic txn_t mode_txn(logic [5:0] pin, mode_e m);
    txn_t n;
    n      = noise();
    n.act  = ACT_MODE;
    n.pin  = pin;
    n.kind = m;
    return n;
  endfunction

  function automatic txn_t event_txn(logic [5:0] pin, ev_kind_e k, logic signed [31:0] s);
    txn_t n;
    n       = noise();
    n.act   = ACT_EVENT;
    n.pin   = pin;
    n.kind  = k;
    n.level = s;
    return n;
  endfunction

  function automatic txn_t clear_txn(logic [2:0] slot);
    txn_t n;
    n      = noise();
    n.act  = ACT_CLEAR;
    n.slot = slot;
    return n;
  endfunction

  function automatic txn_t rule_txn(logic [2:0] slot, logic en, logic [5:0] src,
                                    logic [2:0] op, logic signed [31:0] thr,
                                    logic [5:0] tp, logic signed [31:0] tv,
                                    logic ep, logic [5:0] epin, logic signed [31:0] ev);
    txn_t n;
    n          = noise();
    n.act      = ACT_WRITE;
    n.slot     = slot;
    n.en       = en;
    n.pin      = src;
    n.op       = op;
    n.level    = thr;
    n.then_pin = tp;
    n.then_val = tv;
    n.else_on  = ep;
    n.else_pin = epin;
    n.else_val = ev;
    return n;
  endfunction

  // Mostly well-formed traffic on a few source pins, plus some noise
  function automatic txn_t random_txn();
    txn_t n;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      n = event_txn(($urandom_range(0, 99) < 85) ? 6'(10 + $urandom_range(0, 2))
                                                 : 6'($urandom_range(0, 63)),
                    ($urandom_range(0, 9) < 9) ? ev_kind_e'($urandom_range(1, 2))
                                               : ($urandom_range(0, 1) ? EVK_OTHER
                                                                       : EVK_SPARE),
                    ($urandom_range(0, 3) < 3) ? level_pick() + $urandom_range(0, 6) - 3
                                               : $urandom);
    end else if (r < 70) begin
      n = rule_txn(3'($urandom), ($urandom_range(0, 99) < 85),
                   ($urandom_range(0, 99) < 85) ? 6'(10 + $urandom_range(0, 2))
                                                : 6'($urandom_range(0, 63)),
                   ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 5)) : 3'($urandom),
                   level_pick(),
                   ($urandom_range(0, 9) < 9) ? dest_pick() : 6'($urandom),
                   value_pick(), 1'($urandom),
                   ($urandom_range(0, 99) < 85) ? dest_pick() : 6'($urandom),
                   value_pick());
    end else if (r < 80) begin
      n = clear_txn(3'($urandom));
    end else begin
      n = mode_txn(($urandom_range(0, 99) < 85) ? dest_pick() : 6'($urandom),
                   mode_e'($urandom_range(0, 3)));
    end
    return n;
  endfunction

  function automatic logic dropped(txn_t n);
    return (n.act == ACT_EVENT &&
            (n.pin >= PINS || (n.kind != EVK_DIGITAL && n.kind != EVK_ANALOG))) ||
           (n.act == ACT_MODE && n.pin >= PINS);
  endfunction

  // Present one transaction after a random gap and hold it until accepted
  task automatic send_txn(txn_t n);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    action_i              <= n.act;
    slot_i                <= n.slot;
    enabled_i             <= n.en;
    pin_i                 <= n.pin;
    compare_op_i          <= n.op;
    sample_or_threshold_i <= n.level;
    then_pin_i            <= n.then_pin;
    then_value_i          <= n.then_val;
    else_present_i        <= n.else_on;
    else_pin_i            <= n.else_pin;
    else_value_i          <= n.else_val;
    kind_i                <= n.kind;
    in_valid_i            <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    rst_ni                <= 1'b0;
    in_valid_i            <= 1'b0;
    action_i              <= ACT_EVENT;
    slot_i                <= '0;
    enabled_i             <= 1'b0;
    pin_i                 <= '0;
    compare_op_i          <= CMP_GT;
    sample_or_threshold_i <= '0;
    then_pin_i            <= '0;
    then_value_i          <= '0;
    else_present_i        <= 1'b0;
    else_pin_i            <= '0;
    else_value_i          <= '0;
    kind_i                <= EVK_OTHER;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Output modes, one write to a pin past the table
    send_txn(mode_txn(1, MODE_OUT));
    send_txn(mode_txn(2, MODE_PWM));
    send_txn(mode_txn(3, MODE_SERVO));
    send_txn(mode_txn(39, MODE_PWM));
    send_txn(mode_txn(45, MODE_SERVO));
    // One rule per comparison on pin 10 plus a disabled one; drives include a dead pin and a non-output
    send_txn(rule_txn(0, 1, 10, CMP_GT, 0, 1, 5, 1, 2, -7));
    send_txn(rule_txn(1, 1, 10, CMP_GE, 32'h7fff_ffff, 3, 32'h7fff_ffff, 0, 0, 0));
    send_txn(rule_txn(2, 1, 10, CMP_EQ, -5, 39, 5000, 1, 50, 3));
    send_txn(rule_txn(3, 1, 10, CMP_NE, 100, 4, 1, 1, 2, 32'h8000_0000));
    send_txn(rule_txn(4, 1, 10, CMP_LT, 0, 2, 300, 1, 3, 90));
    send_txn(rule_txn(5, 1, 10, CMP_LE, -5, 3, -1, 1, 1, 0));
    send_txn(rule_txn(6, 0, 10, CMP_GT, 0, 1, 1, 0, 0, 0));
    // Rejected writes: loops back to the source, bad pins, bad comparison
    send_txn(rule_txn(7, 1, 11, CMP_GT, 0, 11, 1, 0, 0, 0));
    send_txn(rule_txn(7, 1, 11, CMP_GT, 0, 1, 1, 1, 11, 0));
    send_txn(rule_txn(7, 1, 45, CMP_GT, 0, 1, 1, 0, 0, 0));
    send_txn(rule_txn(7, 1, 11, OP_BAD, 0, 1, 1, 0, 0, 0));
    send_txn(rule_txn(7, 1, 11, CMP_GT, 0, 40, 1, 0, 0, 0));
    // Events at the sample extremes, then the equality point
    send_txn(event_txn(10, EVK_ANALOG, 32'h8000_0000));
    send_txn(event_txn(10, EVK_DIGITAL, 32'h7fff_ffff));
    send_txn(event_txn(10, EVK_ANALOG, -5));
    // Dropped events
    send_txn(event_txn(10, EVK_OTHER, 0));
    send_txn(event_txn(10, EVK_SPARE, 0));
    send_txn(event_txn(45, EVK_ANALOG, 0));
    // Clear a live slot, then the same slot again
    send_txn(clear_txn(1));
    send_txn(clear_txn(1));

    counted = 0;
    while (counted < ITEMS) begin
      t = random_txn();
      calm <= (counted >= 110 && counted < 150);
      send_txn(t);
      if (!dropped(t)) counted++;
    end

    // Drain outstanding results, then let the block settle
    in_valid_i <= 1'b0;
    calm       <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
design/ptre_pkg.sv
design/ptre_front.sv
design/ptre_queue.sv
design/ptre_back.sv
design/pin_threshold_rule_engine.sv
design/ptre_checker.sv
tb/sv/ptre_drive_checker.sv
tb/sv/pin_threshold_rule_engine_tb.sv
